// File: rtl/core/spli_pkg.sv
// Package with shared widths, mode codes and defaults for the posting list intersect core.
`timescale 1ns / 1ps

package spli_pkg;

    // Field widths of the item and result payloads.
    localparam int ID_W   = 31;
    localparam int FREQ_W = 31;
    localparam int MODE_W = 2;

    // Default list depth and the fixed cap on matches per run.
    localparam int LIST_DEPTH_DEFAULT = 64;
    localparam int MAX_RESULTS        = 64;
    localparam int RES_CNT_W          = $clog2(MAX_RESULTS + 1);

    typedef logic [MODE_W-1:0] mode_t;

    // Command codes carried on the mode field.
    localparam mode_t MODE_APPEND_FIRST  = 2'd0;
    localparam mode_t MODE_APPEND_SECOND = 2'd1;
    localparam mode_t MODE_RUN           = 2'd2;

endpackage

// File: rtl/core/spli_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module spli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/sorted_posting_list_intersect_core.sv
// Top level of the sorted posting list intersect core: list storage and merge sequencer.
`timescale 1ns / 1ps

// Two posting lists of (document id, frequency) entries are loaded one entry per
// transfer (mode 0 for the first list, mode 1 for the second), and appends beyond
// LIST_DEPTH entries are dropped and flagged. A run transfer (mode 2) walks both
// lists with a two-pointer merge built around one 31-bit comparator fed by the
// registered read ports of the list RAMs: every merge step is a memory read, then
// a compare, and the output register can be held by the consumer. Matches leave
// in ascending order with the first list's frequency; the final result of a run
// carries last, and a run without matches gives one result with found low. At
// most 64 matches leave per run. Input ready is low for the whole run; both lists
// and the overflow flag are empty again when it ends. Mode 3 is accepted and
// ignored.
module sorted_posting_list_intersect_core #(
    parameter int LIST_DEPTH = spli_pkg::LIST_DEPTH_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [spli_pkg::MODE_W-1:0] mode,
    input  logic [spli_pkg::ID_W-1:0]   doc_id,
    input  logic [spli_pkg::FREQ_W-1:0] freq,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [spli_pkg::ID_W-1:0]   match_id,
    output logic [spli_pkg::FREQ_W-1:0] match_freq,
    output logic                      found,
    output logic                      overflowed,
    output logic                      last
);

    localparam int AW    = $clog2(LIST_DEPTH);
    localparam int CW    = $clog2(LIST_DEPTH + 1);
    localparam int ID_W  = spli_pkg::ID_W;
    localparam int FR_W  = spli_pkg::FREQ_W;
    localparam int RCW   = spli_pkg::RES_CNT_W;

    // Sequencer state codes.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_CMP   = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [CW-1:0]   first_count_reg, first_count_next;
    logic [CW-1:0]   second_count_reg, second_count_next;
    logic            overflow_reg, overflow_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   j_reg, j_next;
    logic [RCW-1:0]  n_reg, n_next;
    logic            pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0] pend_id_reg, pend_id_next;
    logic [FR_W-1:0] pend_freq_reg, pend_freq_next;
    logic            out_valid_reg, out_valid_next;
    logic [ID_W-1:0] out_id_reg, out_id_next;
    logic [FR_W-1:0] out_freq_reg, out_freq_next;
    logic            out_found_reg, out_found_next;
    logic            out_ovf_reg, out_ovf_next;
    logic            out_last_reg, out_last_next;

    logic                 we_a, we_b;
    logic [ID_W+FR_W-1:0] rdata_a;
    logic [ID_W-1:0]      rdata_b;
    logic [ID_W-1:0]      a_id;
    logic [FR_W-1:0]      a_freq;
    logic                 out_free;
    logic                 in_xfer;

    // First list holds id and frequency together; the second list holds ids only.
    spli_ram #(
        .WIDTH (ID_W + FR_W),
        .DEPTH (LIST_DEPTH)
    ) u_first_ram (
        .clk   (clk),
        .we    (we_a),
        .waddr (first_count_reg[AW-1:0]),
        .wdata ({freq, doc_id}),
        .raddr (i_reg[AW-1:0]),
        .rdata (rdata_a)
    );

    spli_ram #(
        .WIDTH (ID_W),
        .DEPTH (LIST_DEPTH)
    ) u_second_ram (
        .clk   (clk),
        .we    (we_b),
        .waddr (second_count_reg[AW-1:0]),
        .wdata (doc_id),
        .raddr (j_reg[AW-1:0]),
        .rdata (rdata_b)
    );

    assign a_id     = rdata_a[ID_W-1:0];
    assign a_freq   = rdata_a[ID_W+FR_W-1:ID_W];
    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign we_a = in_xfer && (mode == spli_pkg::MODE_APPEND_FIRST)
                  && (first_count_reg != CW'(LIST_DEPTH));
    assign we_b = in_xfer && (mode == spli_pkg::MODE_APPEND_SECOND)
                  && (second_count_reg != CW'(LIST_DEPTH));

    // Sequencer: loads, merge steps and the closing result.
    always_comb
    begin
        state_next        = state_reg;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        overflow_next     = overflow_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        n_next            = n_reg;
        pend_valid_next   = pend_valid_reg;
        pend_id_next      = pend_id_reg;
        pend_freq_next    = pend_freq_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_id_next       = out_id_reg;
        out_freq_next     = out_freq_reg;
        out_found_next    = out_found_reg;
        out_ovf_next      = out_ovf_reg;
        out_last_next     = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    unique case (mode)
                        spli_pkg::MODE_APPEND_FIRST:
                        begin
                            if (we_a)
                            begin
                                first_count_next = first_count_reg + CW'(1);
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        spli_pkg::MODE_APPEND_SECOND:
                        begin
                            if (we_b)
                            begin
                                second_count_next = second_count_reg + CW'(1);
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        spli_pkg::MODE_RUN:
                        begin
                            i_next          = '0;
                            j_next          = '0;
                            n_next          = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_ISSUE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ISSUE:
            begin
                // The RAM reads at i and j this cycle; stop when a list or the cap runs out.
                if ((i_reg < first_count_reg) && (j_reg < second_count_reg)
                    && (n_reg < RCW'(spli_pkg::MAX_RESULTS)))
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_CMP:
            begin
                if (a_id < rdata_b)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_ISSUE;
                end
                else if (a_id > rdata_b)
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = S_ISSUE;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    // A held match is known not to be last once another one turns up.
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_id_next    = pend_id_reg;
                        out_freq_next  = pend_freq_reg;
                        out_found_next = 1'b1;
                        out_ovf_next   = overflow_reg;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_id_next    = a_id;
                    pend_freq_next  = a_freq;
                    i_next          = i_reg + CW'(1);
                    j_next          = j_reg + CW'(1);
                    n_next          = n_reg + RCW'(1);
                    state_next      = S_ISSUE;
                end
            end
            S_FIN:
            begin
                // Close the run with the held match, or with the empty answer.
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_id_next       = pend_valid_reg ? pend_id_reg : '0;
                    out_freq_next     = pend_valid_reg ? pend_freq_reg : '0;
                    out_found_next    = pend_valid_reg;
                    out_ovf_next      = overflow_reg;
                    out_last_next     = 1'b1;
                    pend_valid_next   = 1'b0;
                    first_count_next  = '0;
                    second_count_next = '0;
                    overflow_next     = 1'b0;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            overflow_reg     <= 1'b0;
            i_reg            <= '0;
            j_reg            <= '0;
            n_reg            <= '0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            overflow_reg     <= overflow_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            n_reg            <= n_next;
            pend_valid_reg   <= pend_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_id_reg   <= pend_id_next;
        pend_freq_reg <= pend_freq_next;
        out_id_reg    <= out_id_next;
        out_freq_reg  <= out_freq_next;
        out_found_reg <= out_found_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign match_id   = out_id_reg;
    assign match_freq = out_freq_reg;
    assign found      = out_found_reg;
    assign overflowed = out_ovf_reg;
    assign last       = out_last_reg;

endmodule

// File: rtl/core/spli_checker.sv
// Port-level checker for the posting list intersect core, with its bind statement.
`timescale 1ns / 1ps

module spli_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic [spli_pkg::MODE_W-1:0] mode,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [spli_pkg::ID_W-1:0]   match_id,
    input logic [spli_pkg::FREQ_W-1:0] match_freq,
    input logic                        found,
    input logic                        last
);

    // An empty answer always closes the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> last)
    else $error("empty answer without last");

    // An empty answer carries zero id and frequency.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (match_id == '0 && match_freq == '0))
    else $error("empty answer with non-zero payload");

    // An append finishes in the cycle it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (mode == spli_pkg::MODE_APPEND_FIRST
            || mode == spli_pkg::MODE_APPEND_SECOND)) |=> in_ready)
    else $error("input stalled after an append");

    // A run command closes the input side once it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && mode == spli_pkg::MODE_RUN) |=> !in_ready)
    else $error("input open straight after a run command");

    // A result held by the consumer keeps its id and last flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(match_id) && $stable(last)))
    else $error("stalled result changed");

endmodule

bind sorted_posting_list_intersect_core spli_checker u_spli_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .match_id   (match_id),
    .match_freq (match_freq),
    .found      (found),
    .last       (last)
);
